[hw/rtl/sfcd_pkg.sv]
// ----------------------------------------------------------------------------
// sfcd_pkg
// Shared constants, types and the byte-wide CRC-16 update for the status frame
// decoder.
// ----------------------------------------------------------------------------
package sfcd_pkg;

  localparam int unsigned FrameLen = 21;
  localparam int unsigned CrcSpan  = 19;
  localparam int unsigned PosW     = $clog2(FrameLen);

  localparam logic [15:0] CrcInit = 16'hFFFF;
  localparam logic [15:0] CrcPoly = 16'hA001;

  localparam logic [PosW-1:0] LastPos  = PosW'(FrameLen - 1);
  localparam logic [PosW-1:0] SpanEnd  = PosW'(CrcSpan);

  // Byte offsets inside the frame.
  localparam int unsigned OffLeftSpeed  = 0;
  localparam int unsigned OffBattery    = 2;
  localparam int unsigned OffIrLeft     = 3;
  localparam int unsigned OffOdoLeft    = 5;
  localparam int unsigned OffRightSpeed = 9;
  localparam int unsigned OffIrRight    = 11;
  localparam int unsigned OffOdoRight   = 13;

  localparam int unsigned OutDataW = 128;

  typedef struct packed {
    logic            step;
    logic [PosW-1:0] pos;
    logic            last;
    logic            ok;
  } sfcd_ctl_t;

  function automatic logic [15:0] crc_absorb(input logic [15:0] crc_in,
                                             input logic [7:0]  data);
    logic [15:0] crc;
    crc = crc_in ^ {8'h00, data};
    for (int b = 0; b < 8; b++) begin
      crc = crc[0] ? ((crc >> 1) ^ CrcPoly) : (crc >> 1);
    end
    return crc;
  endfunction

endpackage

[hw/rtl/sfcd_frame_ctrl.sv]
// ----------------------------------------------------------------------------
// sfcd_frame_ctrl
// Byte position counter and running CRC-16/MODBUS register; flags the last
// byte of each frame and a zero CRC residue.
// ----------------------------------------------------------------------------
module sfcd_frame_ctrl
  import sfcd_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       step_i,
  input  logic [7:0] byte_i,
  output sfcd_ctl_t  ctl_o
);

  logic [PosW-1:0] pos_q, pos_d;
  logic [15:0]     crc_q, crc_d;
  logic [15:0]     crc_nxt;
  logic            last;

  assign crc_nxt = crc_absorb(crc_q, byte_i);
  assign last    = (pos_q == LastPos);

  always_comb begin
    pos_d = pos_q;
    crc_d = crc_q;
    if (step_i) begin
      if (last) begin
        pos_d = '0;
        crc_d = CrcInit;
      end else begin
        pos_d = pos_q + PosW'(1);
        crc_d = crc_nxt;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      crc_q <= CrcInit;
    end else begin
      pos_q <= pos_d;
      crc_q <= crc_d;
    end
  end

  assign ctl_o.step = step_i;
  assign ctl_o.pos  = pos_q;
  assign ctl_o.last = last;
  assign ctl_o.ok   = last && (crc_nxt == 16'h0000);

endmodule

[hw/rtl/sfcd_decode.sv]
// ----------------------------------------------------------------------------
// sfcd_decode
// Frame byte capture, baseline latch and held telemetry values; the held
// registers double as the result register.
// ----------------------------------------------------------------------------
module sfcd_decode
  import sfcd_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  sfcd_ctl_t          ctl_i,
  input  logic [7:0]         byte_i,
  output logic               frame_ok_o,
  output logic signed [15:0] left_speed_o,
  output logic signed [15:0] right_speed_o,
  output logic [7:0]         battery_raw_o,
  output logic [7:0]         ir_left_raw_o,
  output logic [7:0]         ir_right_raw_o,
  output logic signed [32:0] odo_left_o,
  output logic signed [32:0] odo_right_o
);

  logic [7:0]  frame_q [CrcSpan];
  logic        armed_q;
  logic [31:0] base_l_q, base_r_q;
  logic        ok_q;
  logic [15:0] spd_l_q, spd_r_q;
  logic [7:0]  bat_q, irl_q, irr_q;
  logic [32:0] odo_l_q, odo_r_q;

  logic [31:0] raw_l, raw_r, sel_l, sel_r;
  logic [32:0] odo_l_d, odo_r_d;

  assign raw_l = {frame_q[OffOdoLeft+3], frame_q[OffOdoLeft+2],
                  frame_q[OffOdoLeft+1], frame_q[OffOdoLeft]};
  assign raw_r = {frame_q[OffOdoRight+3], frame_q[OffOdoRight+2],
                  frame_q[OffOdoRight+1], frame_q[OffOdoRight]};
  assign sel_l = armed_q ? raw_l : base_l_q;
  assign sel_r = armed_q ? raw_r : base_r_q;
  assign odo_l_d = {raw_l[31], raw_l} - {sel_l[31], sel_l};
  assign odo_r_d = {raw_r[31], raw_r} - {sel_r[31], sel_r};

  always_ff @(posedge clk_i) begin
    if (ctl_i.step && (ctl_i.pos < SpanEnd)) begin
      frame_q[ctl_i.pos] <= byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      armed_q  <= 1'b1;
      base_l_q <= '0;
      base_r_q <= '0;
      ok_q     <= 1'b0;
      spd_l_q  <= '0;
      spd_r_q  <= '0;
      bat_q    <= '0;
      irl_q    <= '0;
      irr_q    <= '0;
      odo_l_q  <= '0;
      odo_r_q  <= '0;
    end else if (ctl_i.step && ctl_i.last) begin
      ok_q <= ctl_i.ok;
      if (ctl_i.ok) begin
        spd_l_q <= {frame_q[OffLeftSpeed+1], frame_q[OffLeftSpeed]};
        spd_r_q <= {frame_q[OffRightSpeed+1], frame_q[OffRightSpeed]};
        bat_q   <= frame_q[OffBattery];
        irl_q   <= frame_q[OffIrLeft];
        irr_q   <= frame_q[OffIrRight];
        odo_l_q <= odo_l_d;
        odo_r_q <= odo_r_d;
        armed_q <= 1'b0;
        if (armed_q) begin
          base_l_q <= raw_l;
          base_r_q <= raw_r;
        end
      end
    end
  end

  assign frame_ok_o     = ok_q;
  assign left_speed_o   = spd_l_q;
  assign right_speed_o  = spd_r_q;
  assign battery_raw_o  = bat_q;
  assign ir_left_raw_o  = irl_q;
  assign ir_right_raw_o = irr_q;
  assign odo_left_o     = odo_l_q;
  assign odo_right_o    = odo_r_q;

endmodule

[hw/rtl/sensor_frame_crc_decoder.sv]
// ----------------------------------------------------------------------------
// sensor_frame_crc_decoder
// Checks fixed 21-byte robot status frames with CRC-16/MODBUS and reports the
// held wheel speeds, raw sensor bytes and baseline-relative odometers.
// ----------------------------------------------------------------------------
// Channel  Dir  Width  Contents
// s_axis   in   8      rx_byte, one frame byte per transaction
// m_axis   out  128+1  held telemetry at each frame end, tuser = frame_ok
//
// One byte per cycle sustained while no result is stalled; the last frame
// byte passes the input register and then the result register.
// Every 21st byte yields one result; no resync, frames are counted bytes.
// Reset clears position, CRC, baseline and held values; first good frame
// latches the odometer baseline.
// A stalled result holds all byte processing until it is taken.
// ----------------------------------------------------------------------------
module sensor_frame_crc_decoder
  import sfcd_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [7:0]          s_axis_tdata,   // [7:0] rx_byte
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // [15:0] left_speed, [31:16] right_speed, [39:32] battery_raw,
  // [47:40] ir_left_raw, [55:48] ir_right_raw, [88:56] odo_left,
  // [121:89] odo_right, [127:122] zero
  output logic [OutDataW-1:0] m_axis_tdata,
  output logic                m_axis_tuser    // [0] frame_ok
);

  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       m_valid_q;
  logic       step;
  sfcd_ctl_t  ctl;

  logic               frame_ok;
  logic signed [15:0] left_speed, right_speed;
  logic [7:0]         battery_raw, ir_left_raw, ir_right_raw;
  logic signed [32:0] odo_left, odo_right;

  assign step          = in_valid_q && !(m_valid_q && !m_axis_tready);
  assign s_axis_tready = !in_valid_q || step;

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte_q <= s_axis_tdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      m_valid_q  <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        in_valid_q <= 1'b1;
      end else if (step) begin
        in_valid_q <= 1'b0;
      end
      if (step && ctl.last) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  sfcd_frame_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .byte_i (in_byte_q),
    .ctl_o  (ctl)
  );

  sfcd_decode u_decode (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .ctl_i          (ctl),
    .byte_i         (in_byte_q),
    .frame_ok_o     (frame_ok),
    .left_speed_o   (left_speed),
    .right_speed_o  (right_speed),
    .battery_raw_o  (battery_raw),
    .ir_left_raw_o  (ir_left_raw),
    .ir_right_raw_o (ir_right_raw),
    .odo_left_o     (odo_left),
    .odo_right_o    (odo_right)
  );

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tuser  = frame_ok;
  assign m_axis_tdata  = {6'b0, odo_right, odo_left, ir_right_raw, ir_left_raw,
                          battery_raw, right_speed, left_speed};

  a_no_step_on_stall : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_valid_q && !m_axis_tready) |-> !step)
    else $error("byte processed while result stalled");

  a_result_after_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step && ctl.last) |=> m_valid_q)
    else $error("frame end without result");

  a_ok_only_at_end : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl.ok |-> ctl.last)
    else $error("crc match flagged mid-frame");

  a_pos_advance : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step && !ctl.last) |=> (ctl.pos == $past(ctl.pos) + PosW'(1)))
    else $error("byte position did not advance");

endmodule
